FILE: src/icoe_pkg.sv
// Shared constants, register indexes and the queue entry type of the ICO plane encoder.
package icoe_pkg;

   localparam int MAX_DIMENSION = 256;
   localparam int DIM_W         = 9;
   localparam int COUNT_W       = $clog2(MAX_DIMENSION);
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_FORMAT = 2'd2;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 9'd16;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 9'd16;

   localparam logic FORMAT_24BPP = 1'b0;
   localparam logic FORMAT_32BPP = 1'b1;

   localparam logic PLANE_XOR = 1'b0;
   localparam logic PLANE_AND = 1'b1;

   localparam logic [7:0] FULL_ALPHA = 8'hFF;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [2:0] MASK_TOP   = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified pixel, as handed from the front to the back.
   typedef struct packed {
      logic        fmt;
      logic [7:0]  alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] prod_red;
      logic [15:0] prod_green;
      logic [15:0] prod_blue;
      logic        row_done;
      logic        img_done;
      logic [1:0]  xor_pad;
      logic        and_emit;
      logic [7:0]  and_byte;
      logic [1:0]  and_pad;
   } icoe_entry_type;

endpackage

FILE: src/icoe_front.sv
// Front end: configuration registers, row and mask counters, pixel classification.
module icoe_front
   import icoe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   input  logic                   accept,
   input  logic [7:0]             alpha,
   input  logic [7:0]             red,
   input  logic [7:0]             green,
   input  logic [7:0]             blue,
   input  logic                   mask_set,
   output icoe_entry_type         entry
);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic               format_ff, format_in;
   logic [COUNT_W-1:0] column_ff, column_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic [7:0]         mask_acc_ff, mask_acc_in;
   logic [2:0]         mask_cnt_ff, mask_cnt_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [DIM_W:0]   and_bytes;
   logic [7:0]       acc_merged;
   logic             row_done, img_done, and_emit;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_DIMENSION)) begin
         w_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_DIMENSION)) begin
         h_eff = DIM_W'(MAX_DIMENSION);
      end else begin
         h_eff = height_ff;
      end
   end

   assign row_done   = DIM_W'(column_ff) >= (w_eff - DIM_W'(1));
   assign img_done   = row_done && (DIM_W'(row_ff) >= (h_eff - DIM_W'(1)));
   assign acc_merged = mask_acc_ff | (8'(mask_set) << (MASK_TOP - mask_cnt_ff));
   assign and_emit   = (mask_cnt_ff == MASK_TOP) || row_done;
   // Mask bytes per row, rounded up; padding brings it to a multiple of four.
   assign and_bytes  = ((DIM_W+1)'(w_eff) + (DIM_W+1)'(7)) >> 3;

   always_comb begin
      entry.fmt        = format_ff;
      entry.alpha      = alpha;
      entry.red        = red;
      entry.green      = green;
      entry.blue       = blue;
      entry.prod_red   = 16'(alpha) * 16'(red);
      entry.prod_green = 16'(alpha) * 16'(green);
      entry.prod_blue  = 16'(alpha) * 16'(blue);
      entry.row_done   = row_done;
      entry.img_done   = img_done;
      // At three bytes a pixel the row padding equals the width modulo four.
      entry.xor_pad    = (format_ff == FORMAT_32BPP) ? 2'd0 : w_eff[1:0];
      entry.and_emit   = and_emit;
      entry.and_byte   = acc_merged;
      entry.and_pad    = 2'd0 - and_bytes[1:0];
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      format_in   = format_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      mask_acc_in = mask_acc_ff;
      mask_cnt_in = mask_cnt_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_write_data;
            REG_IMAGE_HEIGHT: height_in = csr_write_data;
            REG_PIXEL_FORMAT: format_in = csr_write_data[0];
            default: ;
         endcase
      end
      if (accept) begin
         if (and_emit) begin
            mask_acc_in = '0;
            mask_cnt_in = '0;
         end else begin
            mask_acc_in = acc_merged;
            mask_cnt_in = mask_cnt_ff + 3'd1;
         end
         if (row_done) begin
            column_in = '0;
            row_in    = img_done ? '0 : row_ff + COUNT_W'(1);
         end else begin
            column_in = column_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
         format_ff   <= FORMAT_24BPP;
         column_ff   <= '0;
         row_ff      <= '0;
         mask_acc_ff <= '0;
         mask_cnt_ff <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         format_ff   <= format_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         mask_acc_ff <= mask_acc_in;
         mask_cnt_ff <= mask_cnt_in;
      end
   end

endmodule

FILE: src/icoe_queue.sv
// Short first-in first-out queue of classified pixels between front and back.
module icoe_queue
   import icoe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  icoe_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           empty,
   output icoe_entry_type head
);

   icoe_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

FILE: src/icoe_back.sv
// Back end: walks each classified pixel byte by byte into the result register.
module icoe_back
   import icoe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  icoe_entry_type entry,
   output logic           q_pop,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output logic [7:0]     rsp_data_byte,
   output logic           rsp_plane,
   output logic           rsp_row_end,
   output logic           rsp_image_end,
   output logic           rsp_last
);

   localparam logic [1:0] PH_XOR_COLOR = 2'd0;
   localparam logic [1:0] PH_XOR_PAD   = 2'd1;
   localparam logic [1:0] PH_AND_BYTE  = 2'd2;
   localparam logic [1:0] PH_AND_PAD   = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] data_ff, data_in;
   logic       plane_ff, plane_in;
   logic       row_end_ff, row_end_in;
   logic       image_end_ff, image_end_in;
   logic       last_ff, last_in;

   logic        advance, phase_end, entry_end, has_xpad, has_apad;
   logic [7:0]  chan;
   logic [15:0] prod;
   logic [16:0] quot_sum;
   logic [7:0]  blended, color_byte, cur_byte;
   logic        cur_row_end;

   assign advance  = !q_empty && (!out_valid_ff || rsp_pop);
   assign has_xpad = entry.row_done && (entry.xor_pad != 2'd0);
   assign has_apad = entry.row_done && (entry.and_pad != 2'd0);

   always_comb begin
      case (step_ff)
         2'd0:    begin chan = entry.blue;  prod = entry.prod_blue;  end
         2'd1:    begin chan = entry.green; prod = entry.prod_green; end
         2'd2:    begin chan = entry.red;   prod = entry.prod_red;   end
         default: begin chan = entry.alpha; prod = '0;               end
      endcase
   end

   // Exact division by 255 for products of two bytes.
   assign quot_sum = 17'(prod) + 17'(prod >> 8) + 17'd1;
   assign blended  = FULL_ALPHA - entry.alpha + quot_sum[15:8];

   always_comb begin
      if (entry.fmt == FORMAT_32BPP || entry.alpha == FULL_ALPHA) begin
         color_byte = chan;
      end else if (entry.alpha == ZERO_BYTE) begin
         color_byte = ZERO_BYTE;
      end else begin
         color_byte = blended;
      end
   end

   always_comb begin
      cur_byte    = ZERO_BYTE;
      phase_end   = 1'b0;
      entry_end   = 1'b0;
      cur_row_end = 1'b0;
      case (phase_ff)
         PH_XOR_COLOR: begin
            cur_byte    = color_byte;
            phase_end   = step_ff == ((entry.fmt == FORMAT_32BPP) ? 2'd3 : 2'd2);
            entry_end   = phase_end && !has_xpad && !entry.and_emit;
            cur_row_end = phase_end && entry.row_done && !has_xpad;
         end
         PH_XOR_PAD: begin
            phase_end   = step_ff == (entry.xor_pad - 2'd1);
            cur_row_end = phase_end;
         end
         PH_AND_BYTE: begin
            cur_byte    = entry.and_byte;
            phase_end   = 1'b1;
            entry_end   = !has_apad;
            cur_row_end = entry.row_done && !has_apad;
         end
         PH_AND_PAD: begin
            phase_end   = step_ff == (entry.and_pad - 2'd1);
            entry_end   = phase_end;
            cur_row_end = phase_end;
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      data_in      = data_ff;
      plane_in     = plane_ff;
      row_end_in   = row_end_ff;
      image_end_in = image_end_ff;
      last_in      = last_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         data_in      = cur_byte;
         plane_in     = (phase_ff == PH_AND_BYTE || phase_ff == PH_AND_PAD) ? PLANE_AND
                                                                            : PLANE_XOR;
         row_end_in   = cur_row_end;
         image_end_in = entry_end && entry.img_done;
         last_in      = entry_end;
         if (entry_end) begin
            phase_in = PH_XOR_COLOR;
            step_in  = 2'd0;
         end else if (phase_end) begin
            step_in = 2'd0;
            case (phase_ff)
               PH_XOR_COLOR: phase_in = has_xpad ? PH_XOR_PAD : PH_AND_BYTE;
               PH_XOR_PAD:   phase_in = PH_AND_BYTE;
               PH_AND_BYTE:  phase_in = PH_AND_PAD;
               default:      phase_in = PH_XOR_COLOR;
            endcase
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   assign q_pop         = advance && entry_end;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_plane     = plane_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_image_end = image_end_ff;
   assign rsp_last      = last_ff;

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      plane_ff     <= plane_in;
      row_end_ff   <= row_end_in;
      image_end_ff <= image_end_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_XOR_COLOR;
         step_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_mid_entry_present: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_XOR_COLOR || step_ff != 2'd0) |-> !q_empty)
      else $error("sequencer is inside a pixel but the queue is empty");

   a_pad_needs_row_end: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_XOR_PAD || phase_ff == PH_AND_PAD) |-> entry.row_done)
      else $error("row padding for a pixel that does not end its row");

   a_alpha_byte_fmt: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_XOR_COLOR && step_ff == 2'd3) |-> (entry.fmt == FORMAT_32BPP))
      else $error("alpha byte sent at three bytes per pixel");

   a_image_end_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && image_end_ff) |-> (last_ff && row_end_ff && plane_ff == PLANE_AND))
      else $error("image end flag off the final byte of a row");

endmodule

FILE: src/ico_xor_and_mask_encoder.sv
// Top level of the ICO XOR and AND plane encoder.
//
// Pixels enter on the req_ channel: a transaction is taken when req_push is high
// and req_full is low. Each pixel carries alpha, red, green, blue and its mask bit,
// in bottom-up row order, left to right. Encoded bytes leave on the rsp_ channel:
// the oldest byte is valid while rsp_empty is low and is taken when rsp_pop is high.
// Each byte is tagged with its plane, row end, image end and last-of-pixel flags.
// The user writes image width, height and XOR depth via the csr_ port while idle.
//
// An accepted pixel is queued, and its bytes are loaded from the queue head into a
// single result register. The back end sends one byte per cycle while the receiver
// keeps taking them; a pixel gives 3 bytes at 24 bits per pixel or 4 at 32, plus
// one per AND byte and one per padding byte at a row end. The front keeps accepting
// while a two-entry queue has room. Reset restores width 16, height 16, 24 bits per
// pixel, clears all counters and empties the queue and the result register. When
// the receiver stalls the result byte holds, the queue fills, and req_full rises
// until bytes are taken again. Keeping csr_ writes to idle is left to the user.
module ico_xor_and_mask_encoder
   import icoe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [7:0]             req_alpha,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic                   req_mask_set,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_plane,
   output logic                   rsp_row_end,
   output logic                   rsp_image_end,
   output logic                   rsp_last
);

   icoe_entry_type front_entry, head_entry;
   logic           accept, q_full, q_empty, q_pop;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   icoe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .alpha            (req_alpha),
      .red              (req_red),
      .green            (req_green),
      .blue             (req_blue),
      .mask_set         (req_mask_set),
      .entry            (front_entry)
   );

   icoe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (head_entry)
   );

   icoe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .entry         (head_entry),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_data_byte (rsp_data_byte),
      .rsp_plane     (rsp_plane),
      .rsp_row_end   (rsp_row_end),
      .rsp_image_end (rsp_image_end),
      .rsp_last      (rsp_last)
   );

endmodule
